>>> src/dbrt_pkg.sv
// Shared constants, types and command/status structs for the reservation table.
`timescale 1ns / 1ps
package dbrt_pkg;

   localparam int BKG_ENTRIES = 64;
   localparam int OVL_ENTRIES = 64;

   localparam int BKG_IDX_W = $clog2(BKG_ENTRIES);
   localparam int OVL_IDX_W = $clog2(OVL_ENTRIES);
   localparam int BKG_CNT_W = $clog2(BKG_ENTRIES + 1);
   localparam int OVL_CNT_W = $clog2(OVL_ENTRIES + 1);
   localparam int SCAN_W    = (BKG_CNT_W > OVL_CNT_W) ? BKG_CNT_W : OVL_CNT_W;

   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BOOKED = 2'd0,
      STATUS_TRIPLE = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
   } span_type;

   typedef struct packed {
      logic load;
      logic clr_idx;
      logic ovl_rd;
      logic bkg_rd;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic ovl_end;
      logic bkg_end;
      logic rd_pend;
      logic ovl_hit;
      logic full;
   } stat_type;

endpackage

>>> src/dbrt_dpath.sv
// Datapath: request latch, booking and overlap memories, scan index, hit counter.
`timescale 1ns / 1ps
module dbrt_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dbrt_pkg::TIME_W-1:0] req_slot_start,
   input  logic [dbrt_pkg::TIME_W-1:0] req_slot_end,
   input  dbrt_pkg::cmd_type         cmd,
   output dbrt_pkg::stat_type        stat
);
   import dbrt_pkg::*;

   span_type ovl_mem [OVL_ENTRIES];
   span_type bkg_mem [BKG_ENTRIES];

   logic [TIME_W-1:0]    s_ff;
   logic [TIME_W-1:0]    e_ff;
   span_type             ovl_rd_ff;
   span_type             bkg_rd_ff;
   logic                 ovl_vld_ff;
   logic                 bkg_vld_ff;
   logic [SCAN_W-1:0]    idx_ff;
   logic [SCAN_W-1:0]    idx_in;
   logic [SCAN_W-1:0]    hits_ff;
   logic [SCAN_W-1:0]    hits_in;
   logic [OVL_CNT_W-1:0] ovl_cnt_ff;
   logic [BKG_CNT_W-1:0] bkg_cnt_ff;
   logic [SCAN_W-1:0]    ovl_cnt_ext;
   logic [SCAN_W:0]      ovl_wa_sum;
   logic                 ovl_wr;
   logic                 meet_ovl;
   logic                 meet_bkg;
   logic                 bkg_hit;
   span_type             new_span;

   assign ovl_cnt_ext = SCAN_W'(ovl_cnt_ff);

   assign meet_ovl = (s_ff < ovl_rd_ff.hi) && (e_ff > ovl_rd_ff.lo);
   assign meet_bkg = (s_ff < bkg_rd_ff.hi) && (e_ff > bkg_rd_ff.lo);
   assign bkg_hit  = bkg_vld_ff && meet_bkg;

   assign new_span.lo = (bkg_rd_ff.lo > s_ff) ? bkg_rd_ff.lo : s_ff;
   assign new_span.hi = (bkg_rd_ff.hi < e_ff) ? bkg_rd_ff.hi : e_ff;

   // Overlaps go in above the committed count; they only count once the request commits.
   assign ovl_wa_sum = {1'b0, ovl_cnt_ext} + {1'b0, hits_ff};
   assign ovl_wr     = bkg_hit && (ovl_wa_sum < (SCAN_W + 1)'(OVL_ENTRIES));

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load || cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.ovl_rd || cmd.bkg_rd) begin
         idx_in = SCAN_W'(idx_ff + 1'b1);
      end
      hits_in = hits_ff;
      if (cmd.load) begin
         hits_in = '0;
      end else if (bkg_hit) begin
         hits_in = SCAN_W'(hits_ff + 1'b1);
      end
   end

   assign stat.ovl_end = (idx_ff == ovl_cnt_ext);
   assign stat.bkg_end = (idx_ff == SCAN_W'(bkg_cnt_ff));
   assign stat.rd_pend = ovl_vld_ff || bkg_vld_ff;
   assign stat.ovl_hit = ovl_vld_ff && meet_ovl;
   assign stat.full    = (bkg_cnt_ff >= BKG_CNT_W'(BKG_ENTRIES)) ||
                         (hits_ff > (SCAN_W'(OVL_ENTRIES) - ovl_cnt_ext));

   always_ff @(posedge clock) begin
      if (reset) begin
         ovl_vld_ff <= 1'b0;
         bkg_vld_ff <= 1'b0;
         idx_ff     <= '0;
         hits_ff    <= '0;
         ovl_cnt_ff <= '0;
         bkg_cnt_ff <= '0;
      end else begin
         ovl_vld_ff <= cmd.ovl_rd;
         bkg_vld_ff <= cmd.bkg_rd;
         idx_ff     <= idx_in;
         hits_ff    <= hits_in;
         if (cmd.commit) begin
            ovl_cnt_ff <= OVL_CNT_W'(ovl_cnt_ext + hits_ff);
            bkg_cnt_ff <= BKG_CNT_W'(bkg_cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff <= req_slot_start;
         e_ff <= req_slot_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ovl_rd) begin
         ovl_rd_ff <= ovl_mem[idx_ff[OVL_IDX_W-1:0]];
      end
      if (ovl_wr) begin
         ovl_mem[ovl_wa_sum[OVL_IDX_W-1:0]] <= new_span;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bkg_rd) begin
         bkg_rd_ff <= bkg_mem[idx_ff[BKG_IDX_W-1:0]];
      end
      if (cmd.commit) begin
         bkg_mem[bkg_cnt_ff[BKG_IDX_W-1:0]] <= '{lo: s_ff, hi: e_ff};
      end
   end

endmodule

>>> src/dbrt_ctrl.sv
// Controller: sequences the two table scans, decides status and holds the result.
`timescale 1ns / 1ps
module dbrt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dbrt_pkg::STATUS_W-1:0] rsp_status,
   output dbrt_pkg::cmd_type           cmd,
   input  dbrt_pkg::stat_type          stat
);
   import dbrt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_OVL,
      ST_SCAN_BKG,
      ST_DECIDE
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic       triple_ff;
   logic       triple_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      triple_in     = triple_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               triple_in = 1'b0;
               state_in  = ST_SCAN_OVL;
            end
         end
         ST_SCAN_OVL: begin
            cmd.ovl_rd = !stat.ovl_end;
            if (stat.ovl_hit) begin
               // drop the rest of the scan; reads in flight are ignored
               cmd.ovl_rd = 1'b0;
               triple_in  = 1'b1;
               state_in   = ST_DECIDE;
            end else if (stat.ovl_end && !stat.rd_pend) begin
               cmd.clr_idx = 1'b1;
               state_in    = ST_SCAN_BKG;
            end
         end
         ST_SCAN_BKG: begin
            cmd.bkg_rd = !stat.bkg_end;
            if (stat.bkg_end && !stat.rd_pend) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (triple_ff) begin
                  rsp_status_in = STATUS_TRIPLE;
               end else if (stat.full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in = STATUS_BOOKED;
                  cmd.commit    = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         triple_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_BOOKED;
      end else begin
         state_ff      <= state_in;
         triple_ff     <= triple_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = STATUS_W'(rsp_status_ff);

endmodule

>>> src/double_booking_reservation_table.sv
// Booking table that allows double bookings and refuses triple bookings.
// Request channel (req_): a half-open span [req_slot_start, req_slot_end) of
// unsigned 32-bit time units, one transfer per booking request.
// Result channel (rsp_): one transfer per request, rsp_status 0 booked,
// 1 refused as a triple booking, 2 refused because a table is full.
// A request walks the overlap table (one entry a cycle through its memory
// port) and then the booking table (one entry a cycle); overlaps found in the
// second walk are written to the overlap memory in the same cycles. A triple
// booking ends the first walk early. One request is in work at a time: the
// next transfer can be taken in the cycle in which the result appears.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the block once that request's
// decision is ready. Reset empties both tables at once (counts to zero);
// the block takes requests as soon as reset is released.
`timescale 1ns / 1ps
module double_booking_reservation_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dbrt_pkg::TIME_W-1:0]   req_slot_start,
   input  logic [dbrt_pkg::TIME_W-1:0]   req_slot_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dbrt_pkg::STATUS_W-1:0] rsp_status
);
   import dbrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dbrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .stat       (stat)
   );

   dbrt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_slot_start (req_slot_start),
      .req_slot_end   (req_slot_end),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

>>> src/dbrt_checker.sv
// Port-level checks for the reservation table, bound to the top level.
`timescale 1ns / 1ps
module dbrt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dbrt_pkg::STATUS_W-1:0] rsp_status
);
   import dbrt_pkg::*;

   // block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   // a result never appears right after its request transfer
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_W'(STATUS_BOOKED)) ||
                    (rsp_status == STATUS_W'(STATUS_TRIPLE)) ||
                    (rsp_status == STATUS_W'(STATUS_FULL)))
      else $error("bad status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind double_booking_reservation_table dbrt_checker u_dbrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status)
);

>>> test/double_booking_reservation_table_tb.sv
// Self-checking testbench for the double-booking reservation table.
`timescale 1ns / 1ps
module double_booking_reservation_table_tb;
   import dbrt_pkg::*;

   localparam int RANDOM_REQUESTS = 930;
   localparam int DRAIN_CYCLES    = 200;
   localparam int STALL_CYCLES    = 400;
   localparam int STALL_AT_RESULT = 150;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [TIME_W-1:0]   req_slot_start = '0;
   logic [TIME_W-1:0]   req_slot_end = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;

   double_booking_reservation_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_slot_start (req_slot_start),
      .req_slot_end   (req_slot_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status)
   );

   always #1 clock = ~clock;

   // Shadow copy of both tables
   span_type    bookings [BKG_ENTRIES];
   span_type    overlaps [OVL_ENTRIES];
   int unsigned booking_cnt = 0;
   int unsigned overlap_cnt = 0;

   span_type    pending_requests[$];
   status_type  expected_status[$];
   int unsigned total_requests = 0;
   int unsigned accepted_cnt = 0;
   int unsigned result_cnt = 0;
   int unsigned fail_cnt = 0;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   function automatic logic spans_meet(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                                       input span_type p);
      return (s < p.hi) && (e > p.lo);
   endfunction

   // Book one request into the shadow tables and return its status
   function automatic status_type book_request(input logic [TIME_W-1:0] s,
                                               input logic [TIME_W-1:0] e);
      int unsigned hits;
      span_type    ovl;
      hits = 0;
      for (int i = 0; i < overlap_cnt; i++)
         if (spans_meet(s, e, overlaps[i])) return STATUS_TRIPLE;
      for (int i = 0; i < booking_cnt; i++)
         if (spans_meet(s, e, bookings[i])) hits++;
      if (booking_cnt >= BKG_ENTRIES || overlap_cnt > OVL_ENTRIES ||
          hits > OVL_ENTRIES - overlap_cnt)
         return STATUS_FULL;
      for (int i = 0; i < booking_cnt; i++) begin
         if (spans_meet(s, e, bookings[i])) begin
            ovl.lo = (bookings[i].lo > s) ? bookings[i].lo : s;
            ovl.hi = (bookings[i].hi < e) ? bookings[i].hi : e;
            overlaps[overlap_cnt] = ovl;
            overlap_cnt++;
         end
      end
      bookings[booking_cnt].lo = s;
      bookings[booking_cnt].hi = e;
      booking_cnt++;
      return STATUS_BOOKED;
   endfunction

   task automatic add_request(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
      span_type r;
      r.lo = s;
      r.hi = e;
      pending_requests = {pending_requests, r};
   endtask

   // Idle mix: receiver-heavy first third, sender-heavy second, none last
   always_comb begin
      if (accepted_cnt < total_requests / 3) begin
         send_idle_pct = 23;
         recv_idle_pct = 48;
      end else if (accepted_cnt < 2 * total_requests / 3) begin
         send_idle_pct = 48;
         recv_idle_pct = 23;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status = {expected_status, book_request(req_slot_start, req_slot_end)};
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_slot_start <= pending_requests[0].lo;
               req_slot_end   <= pending_requests[0].hi;
               pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: once, for a long stretch, so the block backs up
   int unsigned stall_left = 0;
   logic        stall_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && result_cnt == STALL_AT_RESULT) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Result monitor and receiver ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_cnt <= result_cnt + 1;
            if (expected_status.size() == 0) begin
               $error("status: expected none, got %0d", rsp_status);
               fail_cnt++;
            end else begin
               if (rsp_status !== expected_status[0]) begin
                  $error("status: expected %0d, got %0d", expected_status[0], rsp_status);
                  fail_cnt++;
               end
               expected_status.pop_front();
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned       kind;
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] len;
      logic [TIME_W-1:0] edge_vals [4];

      edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

      // directed: empty, plain, double, triple, reversed and extreme spans
      add_request(5, 5);
      add_request(10, 20);
      add_request(15, 25);
      add_request(18, 19);
      add_request(0, TIME_MAX);
      add_request(30, 10);
      add_request(19, 15);
      add_request(24, 26);
      add_request(25, 40);
      add_request(0, 0);
      add_request(TIME_MAX, TIME_MAX);
      add_request(TIME_MAX, 0);
      add_request(TIME_MAX - 1, TIME_MAX);
      add_request(TIME_MAX - 1, TIME_MAX);
      add_request(TIME_MAX - 1, TIME_MAX);
      add_request(32'h8000_0000, 32'h8000_0001);
      add_request(0, 1);
      add_request(0, 1);
      add_request(0, 1);
      add_request(20, 15);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            // short spans in a crowded region, mostly refused as triples
            s   = $urandom_range(4000);
            len = $urandom_range(60, 1);
            add_request(s, s + len);
         end else if (kind < 70) begin
            // wide spans crossing many bookings, fills the overlap table
            s   = $urandom_range(4000);
            len = $urandom_range(5000, 100);
            add_request(s, s + len);
         end else if (kind < 80) begin
            s   = $urandom;
            len = $urandom_range(1000, 1);
            add_request(s, (s > TIME_MAX - len) ? TIME_MAX : s + len);
         end else if (kind < 88) begin
            add_request($urandom, $urandom);
         end else if (kind < 95) begin
            // empty or reversed
            s = $urandom;
            add_request(s, $urandom_range(s));
         end else begin
            add_request(edge_vals[$urandom_range(3)], edge_vals[$urandom_range(3)]);
         end
      end
      total_requests = pending_requests.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt != total_requests) @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
